// ----- hw/rtl/trot_pkg.sv -----
// ----------------------------------------------------------------------------
// Trot gait package
// Shared constants, multiplier command type and the quarter-wave sine table
// builder for the trot gait trajectory generator.
// ----------------------------------------------------------------------------
package trot_pkg;

  // Angle table geometry.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_QTR         = SINE_TABLE_DEPTH / 4;
  localparam int SINE_QTR_AW      = SINE_AW - 1;

  // Fixed-point constants.
  localparam int PHASE_W  = 16;
  localparam int ACC_W    = 50;
  localparam int CYC_GAIN = 41720;   // 4 * round(65536 / (2 * pi))

  // Configuration register indexes.
  localparam logic CFG_WRAP_LIMIT = 1'b0;
  localparam logic CFG_SWING_SPAN = 1'b1;

  // Shared multiplier operations.
  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_LOAD_HI,
    MAC_ADD
  } mac_op_t;

  typedef struct packed {
    mac_op_t            op;
    logic signed [17:0] a;
    logic signed [17:0] b;
  } mac_cmd_t;

  typedef logic [14:0] sine_tab_t [SINE_QTR + 1];

  // Sine in Q14 of entry j of the first quadrant, series evaluated at elaboration.
  function automatic logic [14:0] sine_q14_qtr(input int j);
    longint unsigned x;
    longint unsigned theta;
    longint unsigned term;
    longint          sum;
    longint          r;
    x     = longint'(j) << (20 - SINE_AW);
    theta = (x * 64'd1686629713) >> 18;
    term  = theta;
    sum   = longint'(theta);
    for (int k = 1; k <= 6; k++) begin
      term = (((term * theta) >> 30) * theta) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 64'sd32768) >>> 16;
    if (r > 16384) begin
      r = 16384;
    end
    return r[14:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int j = 0; j <= SINE_QTR; j++) begin
      tab[j] = sine_q14_qtr(j);
    end
    return tab;
  endfunction

endpackage

// ----- hw/rtl/trot_gait_trajectory_generator_top.sv -----
// ----------------------------------------------------------------------------
// Trot gait trajectory generator
// A new tick is taken only in idle, once the previous result has been
// posted; the local fraction comes from the 16-step divider unless it
// saturates at one, and each tick makes sixteen passes through the single
// shared multiplier.
// Reset: synchronous; phase clears, wrap_limit 32768, swing_span 16384.
// ----------------------------------------------------------------------------
module trot_gait_trajectory_generator_top
  import trot_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  // Tick input: phase_step, stride, lift_height, left_turn, right_turn, pad.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,
  // Result: leg1_x..leg4_x, leg1_z..leg4_z, pad.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,
  // Result flag: swing_pair.
  output logic [0:0]   m_axis_tuser
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_ADDR,
    S_SIN,
    S_COS,
    S_M_CYC,
    S_M_Z,
    S_M_XB,
    S_M_XZ,
    S_XZ,
    S_LEG_A,
    S_LEG_B,
    S_LEG_C,
    S_LEG_D,
    S_DONE
  } state_t;

  state_t state;

  logic [PHASE_W-1:0] wrap_limit;
  logic [PHASE_W-1:0] swing_span;
  logic [PHASE_W-1:0] gait_phase;

  logic signed [15:0] xf_reg;
  logic [14:0]        h_reg;
  logic [15:0]        lt_reg;
  logic [15:0]        rt_reg;
  logic               second;
  logic [16:0]        f_reg;
  logic signed [15:0] s_reg;
  logic signed [15:0] c_reg;
  logic [16:0]        cyc_reg;
  logic [14:0]        z_reg;
  logic signed [16:0] xb_reg;
  logic signed [16:0] xz_reg;
  logic [16:0]        lo_reg;
  logic [1:0]         leg_idx;
  logic signed [17:0] leg_x [4];

  logic                    in_acc;
  logic                    out_free;
  logic [PHASE_W-1:0]      step_in;
  logic                    second_in;
  logic [PHASE_W-1:0]      tt;
  logic                    sat_in;
  logic [PHASE_W:0]        phase_sum;
  logic                    div_busy;
  logic                    div_done;
  logic [PHASE_W-1:0]      div_quot;
  logic [SINE_AW-1:0]      angle_sin;
  logic [SINE_AW-1:0]      rom_angle;
  logic signed [15:0]      rom_value;
  mac_cmd_t                mac_cmd;
  logic signed [ACC_W-1:0] acc;
  logic signed [18:0]      cyc_diff;
  logic signed [16:0]      la;
  logic signed [16:0]      lb;
  logic signed [16:0]      ra;
  logic signed [16:0]      rb;
  logic signed [16:0]      fa;
  logic signed [16:0]      fb;
  logic signed [16:0]      x_sel;
  logic signed [21:0]      leg_v;
  logic signed [17:0]      leg_sat;
  logic [14:0]             z_a;
  logic [14:0]             z_b;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Evaluate the current phase; the advanced phase is stored at acceptance.
  assign step_in   = s_axis_tdata[15:0];
  assign second_in = gait_phase > swing_span;
  assign tt        = second_in ? (gait_phase - swing_span) : gait_phase;
  assign sat_in    = tt >= swing_span;
  assign phase_sum = {1'b0, gait_phase} + {1'b0, step_in};

  trot_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (in_acc && !sat_in),
    .num   (tt),
    .den   (swing_span),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sine first, cosine a quarter turn later on the next cycle.
  assign angle_sin = f_reg[15 -: SINE_AW];
  assign rom_angle = (state == S_SIN) ? angle_sin + SINE_AW'(SINE_QTR) : angle_sin;

  trot_sine_rom u_rom (
    .clk   (clk),
    .angle (rom_angle),
    .value (rom_value)
  );

  // Steering factors and per-leg operand selection.
  assign la    = {1'b0, lt_reg};
  assign lb    = 17'sd32768 - la;
  assign ra    = {1'b0, rt_reg};
  assign rb    = 17'sd32768 - ra;
  assign fa    = (leg_idx == 2'd0 || leg_idx == 2'd3) ? la : lb;
  assign fb    = (leg_idx == 2'd0 || leg_idx == 2'd1) ? ra : rb;
  assign x_sel = ((!leg_idx[0]) ^ second) ? xz_reg : xb_reg;

  // Multiplier command for each sequencer step.
  always_comb begin
    mac_cmd = '{op: MAC_HOLD, a: '0, b: '0};
    case (state)
      S_M_CYC: begin
        mac_cmd.op = MAC_LOAD;
        mac_cmd.a  = {{2{s_reg[15]}}, s_reg};
        mac_cmd.b  = 18'(CYC_GAIN);
      end
      S_M_Z: begin
        mac_cmd.op = MAC_LOAD;
        mac_cmd.a  = {3'b000, h_reg};
        mac_cmd.b  = 18'sd16384 - {{2{c_reg[15]}}, c_reg};
      end
      S_M_XB: begin
        mac_cmd.op = MAC_LOAD;
        mac_cmd.a  = {{2{xf_reg[15]}}, xf_reg};
        mac_cmd.b  = {1'b0, cyc_reg};
      end
      S_M_XZ: begin
        mac_cmd.op = MAC_LOAD;
        mac_cmd.a  = {{2{xf_reg[15]}}, xf_reg};
        mac_cmd.b  = 18'sd65536 - {1'b0, cyc_reg};
      end
      S_LEG_A: begin
        mac_cmd.op = MAC_LOAD;
        mac_cmd.a  = {x_sel[16], x_sel};
        mac_cmd.b  = {fa[16], fa};
      end
      S_LEG_B: begin
        mac_cmd.op = MAC_LOAD_HI;
        mac_cmd.a  = {acc[33], acc[33:17]};
        mac_cmd.b  = {fb[16], fb};
      end
      S_LEG_C: begin
        mac_cmd.op = MAC_ADD;
        mac_cmd.a  = {1'b0, lo_reg};
        mac_cmd.b  = {fb[16], fb};
      end
      default: begin
        mac_cmd = '{op: MAC_HOLD, a: '0, b: '0};
      end
    endcase
  end

  trot_mac u_mac (
    .clk (clk),
    .cmd (mac_cmd),
    .acc (acc)
  );

  // Cycloid fraction before clamping, and the saturated leg result.
  assign cyc_diff = $signed({2'b00, f_reg}) - $signed(acc[34:16]);
  assign leg_v    = acc[49:28];
  always_comb begin
    if (leg_v > 22'sd131071) begin
      leg_sat = 18'sh1FFFF;
    end else if (leg_v < -22'sd131072) begin
      leg_sat = 18'sh20000;
    end else begin
      leg_sat = leg_v[17:0];
    end
  end

  assign z_a = second ? 15'd0 : z_reg;
  assign z_b = second ? z_reg : 15'd0;

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wrap_limit    <= 16'd32768;
      swing_span    <= 16'd16384;
      gait_phase    <= '0;
      leg_idx       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WRAP_LIMIT: wrap_limit <= cfg_data;
          CFG_SWING_SPAN: swing_span <= cfg_data;
          default:        wrap_limit <= wrap_limit;
        endcase
      end
      // The completion step below reloads the output register itself.
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            xf_reg     <= s_axis_tdata[31:16];
            h_reg      <= s_axis_tdata[46:32];
            lt_reg     <= s_axis_tdata[62:47];
            rt_reg     <= s_axis_tdata[78:63];
            second     <= second_in;
            gait_phase <= (phase_sum >= {1'b0, wrap_limit}) ? '0 : phase_sum[PHASE_W-1:0];
            if (sat_in) begin
              f_reg <= 17'd65536;
              state <= S_ADDR;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            f_reg <= {1'b0, div_quot};
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_SIN;
        end
        S_SIN: begin
          s_reg <= rom_value;
          state <= S_COS;
        end
        S_COS: begin
          c_reg <= rom_value;
          state <= S_M_CYC;
        end
        S_M_CYC: begin
          state <= S_M_Z;
        end
        S_M_Z: begin
          if (cyc_diff < 19'sd0) begin
            cyc_reg <= '0;
          end else if (cyc_diff > 19'sd65536) begin
            cyc_reg <= 17'd65536;
          end else begin
            cyc_reg <= cyc_diff[16:0];
          end
          state <= S_M_XB;
        end
        S_M_XB: begin
          z_reg <= acc[29:15];
          state <= S_M_XZ;
        end
        S_M_XZ: begin
          xb_reg <= acc[32:16];
          state  <= S_XZ;
        end
        S_XZ: begin
          xz_reg  <= acc[32:16];
          leg_idx <= '0;
          state   <= S_LEG_A;
        end
        S_LEG_A: begin
          state <= S_LEG_B;
        end
        S_LEG_B: begin
          lo_reg <= acc[16:0];
          state  <= S_LEG_C;
        end
        S_LEG_C: begin
          state <= S_LEG_D;
        end
        S_LEG_D: begin
          leg_x[leg_idx] <= leg_sat;
          leg_idx        <= leg_idx + 2'd1;
          state          <= (leg_idx == 2'd3) ? S_DONE : S_LEG_A;
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tdata  <= {4'b0000, z_b, z_a, z_b, z_a,
                              leg_x[3], leg_x[2], leg_x[1], leg_x[0]};
            m_axis_tuser  <= second;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The divider only runs while the sequencer waits on it.
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DIV)
    else $error("divider busy outside the divide step");

  // The stored phase stays below the wrap limit or returns to zero.
  a_phase_wrap: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (gait_phase == '0) || (gait_phase < $past(wrap_limit)))
    else $error("gait phase not wrapped");

  // A finished result is posted and the block returns to idle.
  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && out_free |=> m_axis_tvalid && (state == S_IDLE))
    else $error("result not posted on completion");

endmodule

// ----- hw/rtl/trot_div.sv -----
// ----------------------------------------------------------------------------
// Trot gait fraction divider
// Restoring divider giving floor(num * 2^16 / den) for num < den, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module trot_div
  import trot_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PHASE_W-1:0] num,
  input  logic [PHASE_W-1:0] den,
  output logic               busy,
  output logic               done,
  output logic [PHASE_W-1:0] quot
);

  logic [PHASE_W-1:0] rem;
  logic [PHASE_W-1:0] den_q;
  logic [3:0]         cnt;
  logic [PHASE_W:0]   rem2;
  logic               ge;

  // One trial subtraction per cycle.
  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= num;
        den_q <= den;
        quot  <= '0;
        cnt   <= 4'd15;
        busy  <= 1'b1;
      end else if (busy) begin
        if (ge) begin
          rem <= PHASE_W'(rem2 - {1'b0, den_q});
        end else begin
          rem <= rem2[PHASE_W-1:0];
        end
        quot <= {quot[PHASE_W-2:0], ge};
        cnt  <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/trot_sine_rom.sv -----
// ----------------------------------------------------------------------------
// Trot gait sine table
// Quarter-wave sine table in Q14 with quadrant folding and a registered read.
// ----------------------------------------------------------------------------
module trot_sine_rom
  import trot_pkg::*;
(
  input  logic                      clk,
  input  logic [SINE_AW-1:0]        angle,
  output logic signed [15:0]        value
);

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic [1:0]             quad;
  logic [SINE_QTR_AW-1:0] xi;
  logic [SINE_QTR_AW-1:0] j;
  logic [14:0]            ent;
  logic                   neg;

  // Fold the angle into the first quadrant.
  assign quad = angle[SINE_AW-1 -: 2];
  assign xi   = {1'b0, angle[SINE_AW-3:0]};
  assign j    = quad[0] ? (SINE_QTR_AW'(SINE_QTR) - xi) : xi;

  always_ff @(posedge clk) begin
    ent <= SINE_TAB[j];
    neg <= quad[1];
  end

  assign value = neg ? -$signed({1'b0, ent}) : $signed({1'b0, ent});

endmodule

// ----- hw/rtl/trot_mac.sv -----
// ----------------------------------------------------------------------------
// Trot gait shared multiplier
// One 18x18 signed multiplier feeding a wide accumulator; a product can be
// loaded, loaded shifted up by 17 bits, or added.
// ----------------------------------------------------------------------------
module trot_mac
  import trot_pkg::*;
(
  input  logic                    clk,
  input  mac_cmd_t                cmd,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [35:0]      prod;
  logic signed [ACC_W-1:0] prod_ext;

  assign prod     = $signed(cmd.a) * $signed(cmd.b);
  assign prod_ext = {{(ACC_W - 36){prod[35]}}, prod};

  // Accumulator update per command.
  always_ff @(posedge clk) begin
    case (cmd.op)
      MAC_LOAD:    acc <= prod_ext;
      MAC_LOAD_HI: acc <= prod_ext <<< 17;
      MAC_ADD:     acc <= acc + prod_ext;
      default:     acc <= acc;
    endcase
  end

endmodule

// ----- tb/trot_gait_trajectory_generator_checker.sv -----
// ----------------------------------------------------------------------------
// Trot gait trajectory checker
// Watches the configuration, tick and result channels of the trot gait
// generator. It keeps its own copy of the gait phase and registers, predicts
// the four foot targets of every accepted tick and compares each result
// transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module trot_gait_trajectory_generator_checker
  import trot_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [135:0] m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           pending,
  output int           fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             swing_pair;
    logic [3:0][14:0] leg_z;
    logic [3:0][17:0] leg_x;
  } foot_targets_t;

  // Shadow of the block's registers and gait phase.
  logic [15:0]   wrap_lim;
  logic [15:0]   span;
  logic [15:0]   phase;
  foot_targets_t targets_due [$];

  // Sine of a 20-bit turn fraction in Q14, folded onto the first quadrant
  // and evaluated with a seven-term series.
  function automatic longint sin_q14(input longint unsigned ang);
    longint unsigned a;
    longint unsigned x;
    longint unsigned th;
    longint unsigned tm;
    longint          acc;
    longint          r;
    int              quad;
    int              k;
    a    = ang & 64'hFFFFF;
    quad = int'(a >> 18);
    x    = a & 64'h3FFFF;
    if (quad % 2 == 1) begin
      x = 64'h40000 - x;
    end
    th  = (x * 64'd1686629713) >> 18;
    tm  = th;
    acc = longint'(th);
    for (k = 1; k <= 6; k++) begin
      tm = (((tm * th) >> 30) * th) >> 30;
      tm = tm / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(tm);
      end else begin
        acc = acc + longint'(tm);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (acc + 64'sd32768) >>> 16;
    if (r > 16384) begin
      r = 16384;
    end
    return (quad >= 2) ? -r : r;
  endfunction

  // Forward target scaled by two steering factors in Q14 each, saturated.
  function automatic logic [17:0] steer_leg(input longint x, input longint fa,
                                            input longint fb);
    longint v;
    v = (x * fa * fb) >>> 28;
    if (v > 131071) begin
      v = 131071;
    end else if (v < -131072) begin
      v = -131072;
    end
    return v[17:0];
  endfunction

  // Foot targets for one tick, evaluated at the phase before it advances.
  function automatic foot_targets_t predict_foot_targets(input logic [15:0] t,
                                                         input logic [15:0] sp,
                                                         input logic [79:0] d);
    longint unsigned frac;
    longint unsigned idx;
    longint unsigned ang;
    longint          xf;
    longint          h;
    longint          lt;
    longint          rt;
    longint          s;
    longint          c;
    longint          z;
    longint          cyc;
    longint          xb;
    longint          xz;
    logic            second;
    foot_targets_t   r;
    xf     = longint'($signed(d[31:16]));
    h      = longint'(d[46:32]);
    lt     = longint'(d[62:47]);
    rt     = longint'(d[78:63]);
    second = (t > sp);

    // Local fraction in Q16, saturated at one.
    if (sp == 16'd0) begin
      frac = 64'd65536;
    end else begin
      frac = ((second ? longint'(t - sp) : longint'(t)) << 16) / longint'(sp);
      if (frac > 64'd65536) begin
        frac = 64'd65536;
      end
    end
    idx = (frac * SINE_TABLE_DEPTH) >> 16;
    ang = (idx << 20) / SINE_TABLE_DEPTH;
    s   = sin_q14(ang);
    c   = sin_q14(ang + 64'h40000);

    // Cycloid lift and forward fraction.
    z   = (h * (16384 - c)) >>> 15;
    cyc = longint'(frac) - ((s * CYC_GAIN + 64'sd2147483648) >>> 16) + 32768;
    if (cyc < 0) begin
      cyc = 0;
    end
    if (cyc > 65536) begin
      cyc = 65536;
    end
    xb = (xf * cyc) >>> 16;
    xz = (xf * (65536 - cyc)) >>> 16;

    r = '0;
    if (!second) begin
      r.leg_x[0] = steer_leg(xz, lt, rt);
      r.leg_x[1] = steer_leg(xb, 32768 - lt, rt);
      r.leg_x[2] = steer_leg(xz, 32768 - lt, 32768 - rt);
      r.leg_x[3] = steer_leg(xb, lt, 32768 - rt);
      r.leg_z[0] = z[14:0];
      r.leg_z[2] = z[14:0];
    end else begin
      r.leg_x[0] = steer_leg(xb, lt, rt);
      r.leg_x[1] = steer_leg(xz, 32768 - lt, rt);
      r.leg_x[2] = steer_leg(xb, 32768 - lt, 32768 - rt);
      r.leg_x[3] = steer_leg(xz, lt, 32768 - rt);
      r.leg_z[1] = z[14:0];
      r.leg_z[3] = z[14:0];
      r.swing_pair = 1'b1;
    end
    return r;
  endfunction

  // Compare results first, then take configuration and ticks of this edge.
  always @(posedge clk) begin
    foot_targets_t got;
    foot_targets_t want;
    logic [16:0]   sum;
    int            i;
    if (rst) begin
      wrap_lim = 16'd32768;
      span     = 16'd16384;
      phase    = '0;
      targets_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        for (i = 0; i < 4; i++) begin
          got.leg_x[i] = m_axis_tdata[18 * i +: 18];
          got.leg_z[i] = m_axis_tdata[72 + 15 * i +: 15];
        end
        got.swing_pair = m_axis_tuser[0];
        if (targets_due.size() == 0) begin
          $error("result transaction with no tick waiting");
          fail_count++;
        end else begin
          want = targets_due.pop_front();
          for (i = 0; i < 4; i++) begin
            if (got.leg_x[i] !== want.leg_x[i]) begin
              $error("leg%0d_x: expected %0d, actual %0d", i + 1,
                     $signed(want.leg_x[i]), $signed(got.leg_x[i]));
              fail_count++;
            end
            if (got.leg_z[i] !== want.leg_z[i]) begin
              $error("leg%0d_z: expected %0d, actual %0d", i + 1,
                     want.leg_z[i], got.leg_z[i]);
              fail_count++;
            end
          end
          if (got.swing_pair !== want.swing_pair) begin
            $error("swing_pair: expected %0d, actual %0d",
                   want.swing_pair, got.swing_pair);
            fail_count++;
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WRAP_LIMIT) begin
          wrap_lim = cfg_data;
        end else begin
          span = cfg_data;
        end
      end

      // The phase advances after the targets are evaluated; the sum is
      // compared at full width before it wraps.
      if (s_axis_tvalid && s_axis_tready) begin
        targets_due.push_back(predict_foot_targets(phase, span, s_axis_tdata));
        sum   = {1'b0, phase} + {1'b0, s_axis_tdata[15:0]};
        phase = (sum >= {1'b0, wrap_lim}) ? 16'd0 : sum[15:0];
      end
    end
    pending <= targets_due.size();
  end

endmodule

// ----- tb/trot_gait_trajectory_generator_top_test.sv -----
// ----------------------------------------------------------------------------
// Trot gait trajectory generator testbench
// Drives directed and random gait ticks through several register settings,
// with bursty input, a stalling result side and one long result hold-off.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module trot_gait_trajectory_generator_top_test
  import trot_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Tick layout on s_axis_tdata, highest field first.
  typedef struct packed {
    logic        pad;
    logic [15:0] right_turn;
    logic [15:0] left_turn;
    logic [14:0] lift_height;
    logic [15:0] stride;
    logic [15:0] phase_step;
  } tick_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = CFG_WRAP_LIMIT;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;   // phase_step, stride, lift_height, left_turn,
                                     // right_turn, pad
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;        // leg1_x..leg4_x, leg1_z..leg4_z, pad
  logic [0:0]   m_axis_tuser;        // swing_pair
  int           pending;
  int           fail_count;

  // Sender and receiver pacing.
  int           burst_left = 0;
  bit           no_gaps = 1'b0;
  int           hold_requests = 0;
  int           holds_done = 0;
  int           cur_wrap = 32768;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  trot_gait_trajectory_generator_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  trot_gait_trajectory_generator_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  function automatic tick_t make_tick(input int step, input int stride, input int lift,
                                      input int lt, input int rt);
    tick_t t;
    t             = '0;
    t.phase_step  = step[15:0];
    t.stride      = stride[15:0];
    t.lift_height = lift[14:0];
    t.left_turn   = lt[15:0];
    t.right_turn  = rt[15:0];
    return t;
  endfunction

  // Steps are mostly small against the wrap limit so the phase sweeps both
  // halves; some are arbitrary to hit overflow and wrap.
  function automatic tick_t random_tick(input int wrap);
    tick_t t;
    int    hi;
    hi            = (wrap > 8) ? wrap / 8 : 1;
    t             = '0;
    case ($urandom_range(0, 9))
      0:       t.phase_step = 16'($urandom);
      1:       t.phase_step = 16'd0;
      2:       t.phase_step = 16'hFFFF;
      default: t.phase_step = 16'($urandom_range(1, hi));
    endcase
    t.stride      = 16'($urandom);
    t.lift_height = 15'($urandom);
    t.left_turn   = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 32768));
    t.right_turn  = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 32768));
    return t;
  endfunction

  // One tick transaction; bursts of random length with random gaps between.
  task automatic send_tick(input tick_t t);
    int gap;
    if (!no_gaps && burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
  endtask

  // Stop offering ticks and wait until every result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write both registers; only called while the block is idle.
  task automatic load_config(input int wrap, input int sp);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WRAP_LIMIT;
    cfg_data  <= wrap[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_SWING_SPAN;
    cfg_data  <= sp[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_wrap = wrap;
  endtask

  // Result side: stretches of always ready, random stalls and a fixed
  // toggle pattern, plus a long hold-off whenever one is requested.
  initial begin : result_pacing
    int mode;
    int len;
    int k;
    forever begin
      if (holds_done != hold_requests) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
        holds_done++;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(16, 200);
        for (k = 0; k < len && holds_done == hold_requests; k++) begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= k[2];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int ph;
    int n;
    int wrap;
    int sp;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: both halves, swing end exactly at the span, wrap.
    drain();
    load_config(32768, 16384);
    send_tick(make_tick(4096, 0, 0, 0, 0));
    send_tick(make_tick(4096, 32767, 32767, 32768, 32768));
    send_tick(make_tick(4096, -32768, 32767, 32768, 32768));
    send_tick(make_tick(4096, 32767, 16384, 0, 32768));
    send_tick(make_tick(4096, -32768, 32767, 32768, 0));
    // Steering factors above two drive the complement negative.
    send_tick(make_tick(4096, 32767, 32767, 65535, 65535));
    send_tick(make_tick(4096, -32768, 32767, 65535, 0));
    send_tick(make_tick(4096, 12345, 100, 16384, 16384));
    send_tick(make_tick(4096, 32767, 32767, 0, 65535));

    // Short span: phase beyond two spans, and step overflow at full width.
    drain();
    load_config(65535, 1000);
    send_tick(make_tick(30000, 32767, 32767, 32768, 32768));
    send_tick(make_tick(30000, -32768, 32767, 32768, 32768));
    send_tick(make_tick(65535, 32767, 32767, 65535, 32768));
    send_tick(make_tick(65535, -32768, 1, 0, 0));
    send_tick(make_tick(65534, 255, 32767, 32768, 65535));
    send_tick(make_tick(0, -1, 32767, 16384, 32768));

    // Zero wrap limit and zero swing span.
    drain();
    load_config(0, 0);
    send_tick(make_tick(0, 32767, 32767, 32768, 32768));
    send_tick(make_tick(12345, -32768, 32767, 0, 32768));
    send_tick(make_tick(65535, 32767, 0, 65535, 65535));

    // Smallest wrap limit with the largest span.
    drain();
    load_config(1, 65535);
    send_tick(make_tick(0, -32768, 32767, 32768, 32768));
    send_tick(make_tick(1, 32767, 32767, 32768, 0));
    send_tick(make_tick(0, 1, 32767, 0, 32768));

    // Random settings, each phase started from an idle block.
    for (ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 4))
        0:       wrap = 65535;
        1:       wrap = 1;
        2:       wrap = $urandom_range(1, 65535);
        default: wrap = $urandom_range(2000, 65535);
      endcase
      case ($urandom_range(0, 5))
        0:       sp = 65535;
        1:       sp = 1;
        2:       sp = $urandom_range(1, 65535);
        default: sp = (wrap > 1) ? wrap / 2 : 1;
      endcase
      drain();
      load_config(wrap, sp);
      // One phase runs back to back while the result side holds off.
      if (ph == 2) begin
        no_gaps = 1'b1;
        hold_requests++;
      end
      for (n = 0; n < 116; n++) begin
        send_tick(random_tick(cur_wrap));
      end
      no_gaps = 1'b0;
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
